FILE: design/kst_pkg.sv
// Shared types and constants of the keyword source tokenizer.
package kst_pkg;

	// Longest word or number kept; longer text is cut and flagged
	localparam int MAX_TEXT_LEN = 32;
	localparam int LEN_W        = $clog2(MAX_TEXT_LEN + 1);
	localparam int IDX_W        = $clog2(MAX_TEXT_LEN);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM
	} scan_mode_t;

	// Source of the next output beat
	typedef enum logic [1:0] {
		SRC_TOKEN,   // single token from the held byte (punct, unknown, end)
		SRC_KW,      // keyword token
		SRC_CHAR     // one buffered character of a word or number
	} out_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     latch;     // capture the incoming beat
		logic     append;    // add held byte to the current word or number
		logic     start;     // open a new word or number with the held byte
		logic     clear;     // drop the buffered text after a flush
		logic     rd_en;     // read the buffer at the flush index
		logic     idx_clr;
		logic     idx_inc;
		logic     emit;      // load the output register
		out_src_t src;
		logic     last;      // final beat caused by the held input
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		scan_mode_t mode;
		logic       eos;
		logic       is_space;
		logic       is_letter;
		logic       is_digit;
		logic       cont;        // held byte continues the current text
		logic       kw_hit;      // buffered word is a keyword
		logic       final_char;  // flush index points at the last character
		logic       slot_free;   // output register can take a beat
	} dp_status_t;

endpackage

FILE: design/kst_datapath.sv
// Datapath: held byte, character classes, text buffer, keyword match and output register.
module kst_datapath import kst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_ch,
	input  logic       in_eos,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [4:0] out_kind,
	output logic [7:0] out_char,
	output logic       out_tend,
	output logic       out_trunc,
	output logic       out_last
);

	localparam int NUM_KW     = 6;
	localparam int KW_MAX_LEN = 8;
	localparam int KW_POS_W   = $clog2(KW_MAX_LEN);

	localparam logic [4:0] KIND_IDENT   = 5'd6;
	localparam logic [4:0] KIND_NUMBER  = 5'd7;
	localparam logic [4:0] KIND_LBRACE  = 5'd8;
	localparam logic [4:0] KIND_RBRACE  = 5'd9;
	localparam logic [4:0] KIND_SEMI    = 5'd10;
	localparam logic [4:0] KIND_EQUAL   = 5'd11;
	localparam logic [4:0] KIND_LPAREN  = 5'd12;
	localparam logic [4:0] KIND_RPAREN  = 5'd13;
	localparam logic [4:0] KIND_COMMA   = 5'd14;
	localparam logic [4:0] KIND_UNKNOWN = 5'd15;
	localparam logic [4:0] KIND_END     = 5'd16;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd8};
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
		'{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00},
		'{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
		'{"o", "u", "t", "p", "u", "t", 8'h00, 8'h00},
		'{"s", "t", "a", "g", "e", 8'h00, 8'h00, 8'h00},
		'{"a", "l", "w", "a", "y", "s", 8'h00, 8'h00},
		'{"p", "i", "p", "e", "l", "i", "n", "e"}
	};

	// Character at position pos equals keyword k's character there
	function automatic logic kw_char_ok(input int k, input logic [LEN_W-1:0] pos,
		input logic [7:0] c);
		logic in_range;
		in_range = pos < LEN_W'(KW_LEN[k]);
		return in_range && (KW_TEXT[k][pos[KW_POS_W-1:0]] == c);
	endfunction

	logic [7:0]        ch_q;
	logic              eos_q;
	scan_mode_t        mode_q;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [NUM_KW-1:0] match_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        rd_data_q;
	logic [7:0]        text_mem [MAX_TEXT_LEN];

	logic              is_letter, is_digit, is_space, room;
	logic [NUM_KW-1:0] kw_vec;
	logic [4:0]        kw_kind;
	logic [4:0]        tok_kind;
	logic [7:0]        tok_char;
	logic              final_char;

	// Character classes of the held byte
	assign is_letter = (ch_q >= 8'h41 && ch_q <= 8'h5A) || (ch_q >= 8'h61 && ch_q <= 8'h7A);
	assign is_digit  = ch_q >= 8'h30 && ch_q <= 8'h39;
	assign is_space  = ch_q == 8'h20 || (ch_q >= 8'h09 && ch_q <= 8'h0D);
	assign room      = len_q < LEN_W'(MAX_TEXT_LEN);

	// Keyword hit: every character matched and the length agrees
	always_comb begin
		kw_kind = 5'd0;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			kw_vec[k] = match_q[k] && (len_q == LEN_W'(KW_LEN[k]));
			if (kw_vec[k]) begin
				kw_kind = 5'(k);
			end
		end
	end

	// Single-beat token from the held byte
	always_comb begin
		tok_char = 8'h00;
		if (eos_q) begin
			tok_kind = KIND_END;
		end else begin
			case (ch_q)
				"{":     tok_kind = KIND_LBRACE;
				"}":     tok_kind = KIND_RBRACE;
				";":     tok_kind = KIND_SEMI;
				"=":     tok_kind = KIND_EQUAL;
				"(":     tok_kind = KIND_LPAREN;
				")":     tok_kind = KIND_RPAREN;
				",":     tok_kind = KIND_COMMA;
				default: begin
					tok_kind = KIND_UNKNOWN;
					tok_char = ch_q;
				end
			endcase
		end
	end

	assign final_char = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

	always_comb begin
		status.mode       = mode_q;
		status.eos        = eos_q;
		status.is_space   = is_space;
		status.is_letter  = is_letter;
		status.is_digit   = is_digit;
		status.cont       = (mode_q == MODE_WORD && (is_letter || is_digit
			|| ch_q == CH_UNDERSCORE)) || (mode_q == MODE_NUM && is_digit);
		status.kw_hit     = mode_q == MODE_WORD && !ovf_q && (|kw_vec);
		status.final_char = final_char;
		status.slot_free  = !out_valid || out_ready;
	end

	// Held input beat
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			ch_q  <= in_ch;
			eos_q <= in_eos;
		end
	end

	// Scan state: mode, length, overflow and keyword match bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			match_q <= '0;
		end else if (cmd.start) begin
			mode_q <= is_letter ? MODE_WORD : MODE_NUM;
			len_q  <= LEN_W'(1);
			ovf_q  <= 1'b0;
			for (int k = 0; k < NUM_KW; k++) begin
				match_q[k] <= kw_char_ok(k, '0, ch_q);
			end
		end else if (cmd.append) begin
			if (room) begin
				len_q <= len_q + LEN_W'(1);
				for (int k = 0; k < NUM_KW; k++) begin
					match_q[k] <= match_q[k] && kw_char_ok(k, len_q, ch_q);
				end
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (cmd.clear) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end
	end

	// Text buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			text_mem[0] <= ch_q;
		end else if (cmd.append && room) begin
			text_mem[len_q[IDX_W-1:0]] <= ch_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= text_mem[idx_q];
		end
	end

	// Flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last <= cmd.last;
			case (cmd.src)
				SRC_KW: begin
					out_kind  <= kw_kind;
					out_char  <= 8'h00;
					out_tend  <= 1'b1;
					out_trunc <= 1'b0;
				end
				SRC_CHAR: begin
					out_kind  <= (mode_q == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
					out_char  <= rd_data_q;
					out_tend  <= final_char;
					out_trunc <= ovf_q;
				end
				default: begin
					out_kind  <= tok_kind;
					out_char  <= tok_char;
					out_tend  <= 1'b1;
					out_trunc <= 1'b0;
				end
			endcase
		end
	end

endmodule

FILE: design/kst_ctrl.sv
// Controller: sequences byte handling, keyword and character flushes.
module kst_ctrl import kst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_FLUSH_RD,
		ST_FLUSH_WR
	} state_t;

	state_t state_q, state_d;
	logic   quiet;

	assign in_ready = state_q == ST_IDLE;

	// Held byte gives no beat once the scanner is idle
	assign quiet = !status.eos && (status.is_space || status.is_letter || status.is_digit);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = SRC_TOKEN;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_PROC;
				end
			end
			ST_PROC: begin
				if (!status.eos && status.mode != MODE_IDLE && status.cont) begin
					cmd.append = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.mode != MODE_IDLE) begin
					// held byte ends the pending text
					if (status.kw_hit) begin
						if (status.slot_free) begin
							cmd.emit  = 1'b1;
							cmd.src   = SRC_KW;
							cmd.last  = quiet;
							cmd.clear = 1'b1;
						end
					end else begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_FLUSH_RD;
					end
				end else if (status.eos) begin
					if (status.slot_free) begin
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (status.is_space) begin
					state_d = ST_IDLE;
				end else if (status.is_letter || status.is_digit) begin
					cmd.start = 1'b1;
					state_d   = ST_IDLE;
				end else if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FLUSH_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_FLUSH_WR;
			end
			ST_FLUSH_WR: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_CHAR;
					cmd.last = status.final_char && quiet;
					if (status.final_char) begin
						cmd.clear = 1'b1;
						state_d   = ST_PROC;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_FLUSH_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/keyword_source_tokenizer.sv
// Top level of the keyword source tokenizer: stream ports around controller and datapath.
// Takes one source byte per input beat and emits token beats. A byte that is skipped,
// buffered into a word or number, or gives a single punctuation, unknown or end token
// passes an accept step, then a decode step. When a byte ends a pending word or number,
// a keyword adds one more decode pass; an identifier or number adds one more decode pass
// plus a read and a write step per buffered character, as the buffer read is registered.
// Output beats wait in an output register, so the next byte is accepted while the last
// beat of the previous one is still unclaimed. No clearing pass is needed after reset.
module keyword_source_tokenizer import kst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic        s_axis_tlast,   // end_of_source
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] text_char, [8] token_end, [15:9] zero
	output logic [5:0]  m_axis_tuser,   // [4:0] kind, [5] truncated
	output logic        m_axis_tlast    // last beat caused by the input beat
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [4:0] out_kind;
	logic [7:0] out_char;
	logic       out_tend;
	logic       out_trunc;

	kst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	kst_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (s_axis_tdata),
		.in_eos    (s_axis_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (out_kind),
		.out_char  (out_char),
		.out_tend  (out_tend),
		.out_trunc (out_trunc),
		.out_last  (m_axis_tlast)
	);

	// Pack the result beat
	assign m_axis_tdata = {7'b0, out_tend, out_char};
	assign m_axis_tuser = {out_trunc, out_kind};

endmodule

FILE: tb/tb_keyword_source_tokenizer.sv
// Self-checking testbench for the keyword source tokenizer.
`timescale 1ns / 100ps

module tb_keyword_source_tokenizer import kst_pkg::*;;

	// Token kinds as carried in tuser[4:0]
	localparam logic [4:0] KIND_MODULE  = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd6;
	localparam logic [4:0] KIND_NUMBER  = 5'd7;
	localparam logic [4:0] KIND_LBRACE  = 5'd8;
	localparam logic [4:0] KIND_RBRACE  = 5'd9;
	localparam logic [4:0] KIND_SEMI    = 5'd10;
	localparam logic [4:0] KIND_ASSIGN  = 5'd11;
	localparam logic [4:0] KIND_LPAREN  = 5'd12;
	localparam logic [4:0] KIND_RPAREN  = 5'd13;
	localparam logic [4:0] KIND_COMMA   = 5'd14;
	localparam logic [4:0] KIND_UNKNOWN = 5'd15;
	localparam logic [4:0] KIND_END     = 5'd16;

	localparam int          ITEM_TARGET = 320;
	localparam int          HOLD_CYCLES = 300;
	localparam int          SETTLE      = 12;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] text_char;
		logic       token_end;
		logic       truncated;
		logic       last;
	} token_beat_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] ch
	logic        s_axis_tlast  = 1'b0;    // end_of_source
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;            // [7:0] text_char, [8] token_end, [15:9] zero
	logic [5:0]  m_axis_tuser;            // [4:0] kind, [5] truncated
	logic        m_axis_tlast;

	// Tokenizer shadow state
	scan_mode_t  lex_mode = MODE_IDLE;
	logic [7:0]  word_buf [MAX_TEXT_LEN];
	int          word_len = 0;
	logic        word_cut = 1'b0;
	token_beat_t step_beats[$];
	token_beat_t expected_beats[$];

	string kw_names [6] = '{"module", "input", "output", "stage", "always", "pipeline"};
	string punct_set    = "{};=(),";

	int          beats_sent    = 0;
	int          burst_left    = 0;
	int          mismatches    = 0;
	int unsigned hold_requests = 0;

	keyword_source_tokenizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------
	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	task automatic add_beat(input logic [4:0] kind, input logic [7:0] tc, input logic te,
			input logic tr);
		token_beat_t b;
		b.kind      = kind;
		b.text_char = tc;
		b.token_end = te;
		b.truncated = tr;
		b.last      = 1'b0;
		step_beats.push_back(b);
	endtask

	task automatic buffer_char(input logic [7:0] c);
		if (word_len < MAX_TEXT_LEN) begin
			word_buf[word_len] = c;
			word_len++;
		end else begin
			word_cut = 1'b1;
		end
	endtask

	// Close the pending word or number: one keyword beat or one beat per char
	task automatic flush_word();
		logic [4:0] kind;
		logic       hit;
		if (lex_mode == MODE_IDLE)
			return;
		kind = (lex_mode == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
		if (lex_mode == MODE_WORD && !word_cut) begin
			for (int k = 0; k < 6; k++) begin
				hit = (kw_names[k].len() == word_len);
				for (int i = 0; i < word_len && hit; i++)
					if (kw_names[k][i] != word_buf[i])
						hit = 1'b0;
				if (hit) begin
					add_beat(5'(KIND_MODULE + k), 8'h00, 1'b1, 1'b0);
					lex_mode = MODE_IDLE;
					word_len = 0;
					return;
				end
			end
		end
		for (int i = 0; i < word_len; i++)
			add_beat(kind, word_buf[i], i + 1 == word_len, word_cut);
		lex_mode = MODE_IDLE;
		word_len = 0;
		word_cut = 1'b0;
	endtask

	task automatic lex_idle(input logic [7:0] c);
		if (is_space(c))
			return;
		if (is_letter(c) || is_digit(c)) begin
			if (is_letter(c))
				lex_mode = MODE_WORD;
			else
				lex_mode = MODE_NUM;
			word_len = 0;
			word_cut = 1'b0;
			buffer_char(c);
			return;
		end
		case (c)
			"{": add_beat(KIND_LBRACE, 8'h00, 1'b1, 1'b0);
			"}": add_beat(KIND_RBRACE, 8'h00, 1'b1, 1'b0);
			";": add_beat(KIND_SEMI,   8'h00, 1'b1, 1'b0);
			"=": add_beat(KIND_ASSIGN, 8'h00, 1'b1, 1'b0);
			"(": add_beat(KIND_LPAREN, 8'h00, 1'b1, 1'b0);
			")": add_beat(KIND_RPAREN, 8'h00, 1'b1, 1'b0);
			",": add_beat(KIND_COMMA,  8'h00, 1'b1, 1'b0);
			default: add_beat(KIND_UNKNOWN, c, 1'b1, 1'b0);
		endcase
	endtask

	task automatic predict_tokens(input logic [7:0] c, input logic eos);
		token_beat_t b;
		step_beats.delete();
		if (eos) begin
			flush_word();
			add_beat(KIND_END, 8'h00, 1'b1, 1'b0);
		end else if (lex_mode == MODE_WORD) begin
			if (is_letter(c) || is_digit(c) || c == "_") begin
				buffer_char(c);
			end else begin
				flush_word();
				lex_idle(c);
			end
		end else if (lex_mode == MODE_NUM) begin
			if (is_digit(c)) begin
				buffer_char(c);
			end else begin
				flush_word();
				lex_idle(c);
			end
		end else begin
			lex_idle(c);
		end
		for (int i = 0; i < step_beats.size(); i++) begin
			b      = step_beats[i];
			b.last = (i == step_beats.size() - 1);
			expected_beats.push_back(b);
		end
	endtask

	// ---------------------------------------------------------------
	// Source side: bursts with random gaps
	// ---------------------------------------------------------------
	task automatic send_beat(input logic [7:0] c, input logic eos);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		predict_tokens(c, eos);
		beats_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// Random word (letter first, then letters, digits, underscore) or number
	task automatic send_word(input int len, input logic numeric);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			if (numeric)
				c = 8'($urandom_range("9", "0"));
			else if (i == 0 || $urandom_range(2) == 0)
				c = ($urandom_range(1)) ? 8'($urandom_range("z", "a"))
					: 8'($urandom_range("Z", "A"));
			else if ($urandom_range(3) == 0)
				c = "_";
			else
				c = 8'($urandom_range("9", "0"));
			send_beat(c, 1'b0);
		end
	endtask

	task automatic send_separator();
		if ($urandom_range(1))
			send_beat(punct_set[$urandom_range(6)], 1'b0);
		else if ($urandom_range(5) == 0)
			send_beat(" ", 1'b0);
		else
			send_beat(8'($urandom_range(13, 9)), 1'b0);
	endtask

	// Stop offering and wait for every expected token beat
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Sink side: stall pattern plus requested long hold-offs
	// ---------------------------------------------------------------
	initial begin : sink_pattern
		int unsigned phase_left;
		int unsigned stall_pct;
		int unsigned hold_cnt;
		int unsigned holds_done;
		phase_left = 0;
		stall_pct  = 0;
		hold_cnt   = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				hold_cnt   = HOLD_CYCLES;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(300, 40);
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			phase_left--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Token beat checker
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected token beat: kind %0d, text_char %0d",
					m_axis_tuser[4:0], m_axis_tdata[7:0]);
				mismatches++;
			end else begin
				want = expected_beats.pop_front();
				check_field("kind",      want.kind,      m_axis_tuser[4:0]);
				check_field("text_char", want.text_char, m_axis_tdata[7:0]);
				check_field("token_end", want.token_end, m_axis_tdata[8]);
				check_field("truncated", want.truncated, m_axis_tuser[5]);
				check_field("last",      want.last,      m_axis_tlast);
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Keyword, identifier, number, punctuation other than braces, unknown bytes, end marks
	task automatic test_directed();
		send_string("module(");
		send_string("x9_)");
		send_string("07;");
		send_string("=,");
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat("_", 1'b0);      // leading underscore is unknown
		send_beat(8'h09, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_string("a");
		send_beat(8'hFF, 1'b1);    // end mark flushes the pending word
		send_beat(8'h00, 1'b1);    // repeated end mark
	endtask

	// Text at, just over and well over the buffer size
	task automatic test_text_limit();
		send_word(MAX_TEXT_LEN, 1'b0);
		send_beat(" ", 1'b0);
		send_word(MAX_TEXT_LEN + 1, 1'b0);
		send_beat(";", 1'b0);
		send_word(MAX_TEXT_LEN + 6, 1'b1);
		send_beat(",", 1'b0);
		send_string("stage");      // overflow flag must not carry over
		send_beat(8'h00, 1'b1);
	endtask

	// Sink holds off while the source keeps offering
	task automatic test_backpressure();
		hold_requests++;
		for (int i = 0; i < 6; i++) begin
			send_word(10, 1'b0);
			send_beat(",", 1'b0);
		end
	endtask

	// Mostly well-formed source text with random content, plus noise
	task automatic test_random_source();
		int pick;
		string s;
		while (beats_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				s = kw_names[$urandom_range(5)];
				case ($urandom_range(5))
					0: s = s.substr(0, s.len() - 2);
					1: s = {s, "_"};
					2: s[0] = s[0] ^ 8'h20;
					default: ;
				endcase
				send_string(s);
				if ($urandom_range(9) < 8)
					send_separator();
			end else if (pick < 52) begin
				send_word($urandom_range(12, 1), 1'b0);
				if ($urandom_range(9) < 7)
					send_separator();
			end else if (pick < 64) begin
				send_word($urandom_range(10, 1), 1'b1);
				if ($urandom_range(9) < 6)
					send_separator();
			end else if (pick < 78) begin
				send_separator();
			end else if (pick < 90) begin
				send_beat(8'($urandom_range(255)), 1'b0);
			end else if (pick < 96) begin
				send_beat(8'($urandom_range(255)), 1'b1);
			end else begin
				send_word($urandom_range(MAX_TEXT_LEN + 8, MAX_TEXT_LEN - 2),
					$urandom_range(1));
				send_separator();
			end
		end
	endtask

	initial begin : main
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_text_limit();
		test_backpressure();
		wait_drained();
		test_random_source();
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
